### rtl/skis_pkg.sv
// Shared types and codes for the sorted key index search block.
// No dependencies; compiled before every other file of the block.
package skis_pkg;

  // Request codes carried in req_type; code 3 is unused and does nothing
  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_kind_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_ACT,
    ST_WAIT,
    ST_DONE
  } seq_state_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic cmp_en;  // register compare flags against the held request
    logic ins_en;  // commit a shift insert
  } cell_ctl_t;

  // Compare flags a cell hands to its right-hand neighbour
  typedef struct packed {
    logic ahead;   // valid and sorts before or equal to the request key
    logic eq;      // valid and equal to the request key
  } cell_flag_t;

  localparam int unsigned LEN_W    = 4;
  localparam int unsigned OFFSET_W = 32;
  localparam int unsigned RAW_KEY_W = 64;
  localparam int unsigned TOTAL_W  = 9;

endpackage

### rtl/skis_if.sv
// Request and response channel interfaces for the sorted key index search.
// Valid/ready handshake; a request moves when both are high at a clock edge.
interface skis_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] key_chars;
  logic [3:0]  key_length;
  logic [31:0] record_offset;

  modport source (output valid, req_type, key_chars, key_length, record_offset,
                  input ready);
  modport sink   (input valid, req_type, key_chars, key_length, record_offset,
                  output ready);
endinterface

interface skis_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] result_offset;
  logic        status;
  logic [8:0]  entry_total;

  modport source (output valid, found, result_offset, status, entry_total,
                  input ready);
  modport sink   (input valid, found, result_offset, status, entry_total,
                  output ready);
endinterface

### rtl/sorted_key_index_search.sv
// Sorted key index search: a row of table cells kept in key order.
// Add, clear and unused requests step through the compare, act and done states;
// lookup also waits in the wait state for the registered OR tree before done.
// One request in flight: the next is taken the cycle after the response loads.
// Synchronous active-high reset empties the table and clears the channels.
module sorted_key_index_search
  import skis_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned KEY_CHARS   = 8
) (
  input logic   clk,
  input logic   rst,
  skis_req_if.sink   req,
  skis_rsp_if.source rsp
);

  localparam int unsigned KW = 8 * KEY_CHARS;          // stored key bits
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1); // entry count bits

  // ---------------------------------------------------------------------
  // Held request, in canonical form: length saturated to KEY_CHARS, bytes
  // past the length zeroed, so with length compared first, plain unsigned compare gives key order.
  // ---------------------------------------------------------------------
  logic [1:0]          rq_type;
  logic [KW-1:0]       rq_key;
  logic [LEN_W-1:0]    rq_len;
  logic [OFFSET_W-1:0] rq_off;

  logic [LEN_W-1:0]    canon_len;
  logic [KW-1:0]       canon_key;

  always_comb begin
    canon_len = (req.key_length > LEN_W'(KEY_CHARS)) ? LEN_W'(KEY_CHARS)
                                                      : req.key_length;
    for (int b = 0; b < KEY_CHARS; b++) begin
      canon_key[KW-1-8*b -: 8] = (LEN_W'(b) < canon_len) ?
                                 req.key_chars[RAW_KEY_W-1-8*b -: 8] : 8'd0;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  seq_state_t state, state_next;
  logic       accept;
  logic       out_free;
  logic       is_add, is_lookup, is_clear;
  logic       full;
  logic       tree_done;
  logic       tree_start;
  logic       out_load;
  cell_ctl_t  ctl;

  logic [CW-1:0]       count;
  logic                res_found;
  logic [OFFSET_W-1:0] res_offset;
  logic                res_status;
  logic [OFFSET_W:0]   tree_root;

  assign accept    = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;
  assign is_add    = rq_type == REQ_ADD;
  assign is_lookup = rq_type == REQ_LOOKUP;
  assign is_clear  = rq_type == REQ_CLEAR;
  assign full      = count == CW'(TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_CMP;
      ST_CMP:  state_next = ST_ACT;
      ST_ACT:  state_next = is_lookup ? ST_WAIT : ST_DONE;
      ST_WAIT: if (tree_done) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready  = 1'b0;
    ctl        = '0;
    tree_start = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: req.ready  = !rst;
      ST_CMP:  ctl.cmp_en = 1'b1;
      ST_ACT: begin
        ctl.ins_en = is_add && !full;
        tree_start = is_lookup;
      end
      ST_DONE: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rq_type <= req.req_type;
      rq_key  <= canon_key;
      rq_len  <= canon_len;
      rq_off  <= req.record_offset;
    end
  end

  // Entry count; a refused add or an unused code leaves it alone
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (state == ST_ACT) begin
      if (is_clear) begin
        count <= '0;
      end else if (is_add && !full) begin
        count <= count + CW'(1);
      end
    end
  end

  // Result fields gathered before the response register
  always_ff @(posedge clk) begin
    if (state == ST_ACT) begin
      res_found  <= 1'b0;
      res_offset <= '0;
      res_status <= is_add && full;
    end else if (state == ST_WAIT && tree_done) begin
      res_found  <= tree_root[OFFSET_W];
      res_offset <= tree_root[OFFSET_W-1:0];
    end
  end

  // Response register: parts the two channels
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.found         <= res_found;
      rsp.result_offset <= res_offset;
      rsp.status        <= res_status;
      rsp.entry_total   <= TOTAL_W'(count);
    end
  end

  // ---------------------------------------------------------------------
  // Cell row: slot i is valid while i < count. Each slot compares with the
  // held request in parallel; an add shifts every slot right of the insert
  // point one place, taking its left neighbour's entry.
  // ---------------------------------------------------------------------
  cell_flag_t          cflag [TABLE_DEPTH];
  logic [KW-1:0]       ckey  [TABLE_DEPTH];
  logic [LEN_W-1:0]    clen  [TABLE_DEPTH];
  logic [OFFSET_W-1:0] coff  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0][OFFSET_W:0] leaf;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    cell_flag_t          pflag;
    logic [KW-1:0]       pkey;
    logic [LEN_W-1:0]    plen;
    logic [OFFSET_W-1:0] poff;
    logic                hit;
    logic [OFFSET_W-1:0] hit_off;

    if (i == 0) begin : g_head
      // nothing to the left: never shift, never a left match
      assign pflag = '{ahead: 1'b1, eq: 1'b0};
      assign pkey  = '0;
      assign plen  = '0;
      assign poff  = '0;
    end else begin : g_link
      assign pflag = cflag[i-1];
      assign pkey  = ckey[i-1];
      assign plen  = clen[i-1];
      assign poff  = coff[i-1];
    end

    skis_cell #(
      .KW (KW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .valid     (CW'(i) < count),
      .req_key   (rq_key),
      .req_len   (rq_len),
      .req_off   (rq_off),
      .prev_flag (pflag),
      .prev_key  (pkey),
      .prev_len  (plen),
      .prev_off  (poff),
      .flag      (cflag[i]),
      .key       (ckey[i]),
      .len       (clen[i]),
      .off       (coff[i]),
      .hit       (hit),
      .hit_off   (hit_off)
    );

    assign leaf[i] = {hit, hit_off};
  end

  // At most one slot hits, so an OR tree yields its offset and found bit
  skis_or_tree #(
    .N (TABLE_DEPTH),
    .W (OFFSET_W + 1)
  ) u_tree (
    .clk   (clk),
    .rst   (rst),
    .start (tree_start),
    .leaf  (leaf),
    .done  (tree_done),
    .root  (tree_root)
  );

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_full_add_keeps: assert property (@(posedge clk) disable iff (rst)
    state == ST_ACT && is_add && full |=> $stable(count))
    else $error("refused add changed the entry count");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    state == ST_ACT && is_clear |=> count == '0)
    else $error("clear left entries behind");

  a_tree_in_wait: assert property (@(posedge clk) disable iff (rst)
    tree_done |-> state == ST_WAIT)
    else $error("lookup tree finished outside lookup wait");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.found |-> !rsp.status)
    else $error("lookup hit flagged as refused add");
`endif

endmodule

### rtl/skis_cell.sv
// One table slot: holds a key, its length and record offset, compares them
// with the held request and shifts in from its left neighbour. Uses skis_pkg.
module skis_cell
  import skis_pkg::*;
#(
  parameter int unsigned KW = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  cell_ctl_t           ctl,
  input  logic                valid,
  input  logic [KW-1:0]       req_key,
  input  logic [LEN_W-1:0]    req_len,
  input  logic [OFFSET_W-1:0] req_off,
  input  cell_flag_t          prev_flag,
  input  logic [KW-1:0]       prev_key,
  input  logic [LEN_W-1:0]    prev_len,
  input  logic [OFFSET_W-1:0] prev_off,
  output cell_flag_t          flag,
  output logic [KW-1:0]       key,
  output logic [LEN_W-1:0]    len,
  output logic [OFFSET_W-1:0] off,
  output logic                hit,
  output logic [OFFSET_W-1:0] hit_off
);

  logic lt_len, eq_len;

  assign lt_len = len < req_len;
  assign eq_len = len == req_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= '0;
    end else if (ctl.cmp_en) begin
      flag.ahead <= valid && (lt_len || (eq_len && key <= req_key));
      flag.eq    <= valid && eq_len && (key == req_key);
    end
  end

  // Left neighbour not before the key: insert point is to our left, shift.
  always_ff @(posedge clk) begin
    if (ctl.ins_en) begin
      if (!prev_flag.ahead) begin
        key <= prev_key;
        len <= prev_len;
        off <= prev_off;
      end else if (!flag.ahead) begin
        key <= req_key;
        len <= req_len;
        off <= req_off;
      end
    end
  end

  // Equal keys sit together; the leftmost one is the earliest inserted
  assign hit     = flag.eq && !prev_flag.eq;
  assign hit_off = hit ? off : '0;

endmodule

### rtl/skis_or_tree.sv
// Registered OR reduction tree; one register level per tree level.
// Collects the single matching cell's offset. No package dependency.
module skis_or_tree #(
  parameter int unsigned N = 256,
  parameter int unsigned W = 33
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [N-1:0][W-1:0] leaf,
  output logic                done,
  output logic [W-1:0]        root
);

  localparam int unsigned LVL = $clog2(N);
  localparam int unsigned P2  = 1 << LVL;

  logic [W-1:0] node [1:2*P2-1];
  logic [LVL:0] vpipe;

  for (genvar k = 0; k < P2; k++) begin : g_leaf
    if (k < N) begin : g_used
      always_ff @(posedge clk) begin
        node[P2+k] <= leaf[k];
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        node[P2+k] <= '0;
      end
    end
  end

  for (genvar n = 1; n < P2; n++) begin : g_node
    always_ff @(posedge clk) begin
      node[n] <= node[2*n] | node[2*n+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[LVL-1:0], start};
    end
  end

  assign done = vpipe[LVL];
  assign root = node[1];

endmodule

### sim/skis_index_scoreboard_pkg.sv
// Scoreboard for the sorted key index search: a key-ordered table predictor
// and the queue of responses it expects. Depends on skis_pkg.
package skis_index_scoreboard_pkg;
  import skis_pkg::*;

  localparam int unsigned INDEX_DEPTH   = 256;
  localparam int unsigned MAX_KEY_CHARS = 8;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam logic [1:0]  REQ_UNUSED    = 2'd3;

  typedef struct packed {
    logic [RAW_KEY_W-1:0] key;
    logic [LEN_W-1:0]     len;
    logic [OFFSET_W-1:0]  offset;
  } index_entry_t;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] offset;
    logic                status;
    logic [TOTAL_W-1:0]  total;
  } index_answer_t;

  class index_scoreboard;
    index_entry_t  entries[$];
    index_answer_t answers_due[$];
    int unsigned   mismatches;
    int unsigned   answers_seen;

    function new();
      mismatches   = 0;
      answers_seen = 0;
    endfunction

    static function logic [LEN_W-1:0] fold_len(logic [LEN_W-1:0] raw);
      return (raw > MAX_KEY_CHARS) ? LEN_W'(MAX_KEY_CHARS) : raw;
    endfunction

    // clears every character past the key length
    static function logic [RAW_KEY_W-1:0] fold_key(logic [RAW_KEY_W-1:0] raw,
                                                   logic [LEN_W-1:0] len);
      if (len == 0) return '0;
      return raw & ({RAW_KEY_W{1'b1}} << (RAW_KEY_W - 8 * int'(len)));
    endfunction

    // shorter keys first, then by character value
    static function int key_order(logic [RAW_KEY_W-1:0] ka, logic [LEN_W-1:0] la,
                                  logic [RAW_KEY_W-1:0] kb, logic [LEN_W-1:0] lb);
      if (la != lb) return (la < lb) ? -1 : 1;
      if (ka != kb) return (ka < kb) ? -1 : 1;
      return 0;
    endfunction

    function int unsigned pending();
      return answers_due.size();
    endfunction

    function void note_request(logic [1:0] kind, logic [RAW_KEY_W-1:0] chars,
                               logic [LEN_W-1:0] raw_len, logic [OFFSET_W-1:0] offset);
      logic [LEN_W-1:0]     len;
      logic [RAW_KEY_W-1:0] key;
      index_answer_t        ans;
      int                   pos;
      len = fold_len(raw_len);
      key = fold_key(chars, len);
      ans = '0;
      pos = 0;
      case (kind)
        REQ_ADD: begin
          if (entries.size() >= INDEX_DEPTH) begin
            ans.status = 1'b1;
          end else begin
            // equal keys stay in arrival order
            while (pos < entries.size() &&
                   key_order(entries[pos].key, entries[pos].len, key, len) <= 0)
              pos++;
            entries.insert(pos, index_entry_t'{key, len, offset});
          end
        end
        REQ_LOOKUP: begin
          while (pos < entries.size() &&
                 key_order(entries[pos].key, entries[pos].len, key, len) < 0)
            pos++;
          if (pos < entries.size() &&
              key_order(entries[pos].key, entries[pos].len, key, len) == 0) begin
            ans.found  = 1'b1;
            ans.offset = entries[pos].offset;
          end
        end
        REQ_CLEAR: entries.delete();
        default: ;
      endcase
      ans.total = TOTAL_W'(entries.size());
      answers_due = {answers_due, ans};
    endfunction

    function void flag(string what, index_answer_t exp, index_answer_t got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("%0t response %0d %s: exp found=%0b off=%h status=%0b total=%0d",
                 $time, answers_seen, what, exp.found, exp.offset, exp.status, exp.total);
        $display("    got found=%0b off=%h status=%0b total=%0d",
                 got.found, got.offset, got.status, got.total);
      end
    endfunction

    function void check_response(index_answer_t got);
      index_answer_t exp;
      answers_seen++;
      if (answers_due.size() == 0) begin
        flag("unexpected", '0, got);
        return;
      end
      exp = answers_due.pop_front();
      if (got.found !== exp.found || got.offset !== exp.offset ||
          got.status !== exp.status || got.total !== exp.total)
        flag("mismatch", exp, got);
    endfunction

    function void close_out();
      if (answers_due.size() != 0) begin
        mismatches += answers_due.size();
        $display("%0d responses never arrived", answers_due.size());
      end
    endfunction
  endclass

endpackage

### sim/tb_sorted_key_index_search.sv
// Top-level testbench for sorted_key_index_search: drives requests, paces
// responses and checks them. Depends on skis_pkg, skis_if and the scoreboard.
module tb_sorted_key_index_search;
  timeunit 1ns;
  timeprecision 1ps;
  import skis_pkg::*;
  import skis_index_scoreboard_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 1000; // cycles with no handshake at all
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned HOLD_CYCLES  = 60;   // long receiver hold-off
  localparam int unsigned MIX_REQUESTS = 200;
  localparam int unsigned POOL_MAX     = 64;
  localparam int unsigned SPARE_ADDS   = 6;    // adds refused once the table is full

  typedef struct packed {
    logic [RAW_KEY_W-1:0] chars;
    logic [LEN_W-1:0]     len;
  } req_key_t;

  logic clk;
  logic rst;

  skis_req_if req_ch();
  skis_rsp_if rsp_ch();

  sorted_key_index_search #(
    .TABLE_DEPTH(INDEX_DEPTH),
    .KEY_CHARS  (MAX_KEY_CHARS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  index_scoreboard sb = new();

  // keys recently added, raw as sent; used to aim lookups and duplicates
  req_key_t    key_pool[$];
  int unsigned requests_sent;
  int unsigned responses_taken;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Monitors: everything sampled at the rising edge, before the block updates.
  // A request noted in the same cycle as a response cannot have caused it, so
  // noting first is safe.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready)
      sb.note_request(req_ch.req_type, req_ch.key_chars, req_ch.key_length,
                      req_ch.record_offset);
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_response(index_answer_t'{rsp_ch.found, rsp_ch.result_offset,
                                        rsp_ch.status, rsp_ch.entry_total});
  end

  // Watchdog: any handshake on either channel restarts the count
  initial begin
    int unsigned quiet;
    quiet = 0;
    do begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet = 0;
      else
        quiet++;
    end while (quiet < IDLE_LIMIT);
    $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [OFFSET_W-1:0] pick_offset();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Mix of noise, keys from a tiny alphabet (lots of shared prefixes and
  // ties), pool hits with fresh padding past the length, and near misses.
  function automatic req_key_t pick_key();
    req_key_t             k;
    logic [LEN_W-1:0]     clen;
    logic [RAW_KEY_W-1:0] mask;
    int unsigned          sel;
    sel     = $urandom_range(0, 9);
    k.chars = {$urandom(), $urandom()};
    k.len   = LEN_W'($urandom_range(0, 15));
    if (sel < 2) return k;
    if (sel < 5 || key_pool.size() == 0) begin
      for (int b = 0; b < 8; b++) begin
        case ($urandom_range(0, 3))
          0: k.chars[63 - 8*b -: 8] = 8'h00;
          1: k.chars[63 - 8*b -: 8] = 8'h41;
          2: k.chars[63 - 8*b -: 8] = 8'h42;
          default: k.chars[63 - 8*b -: 8] = 8'hFF;
        endcase
      end
      if ($urandom_range(0, 3) != 0) k.len = LEN_W'($urandom_range(1, 4));
      return k;
    end
    k    = key_pool[$urandom_range(0, key_pool.size() - 1)];
    clen = index_scoreboard::fold_len(k.len);
    mask = index_scoreboard::fold_key('1, clen);
    if (sel == 9) begin
      // near miss: one bit flipped inside the key, or length nudged by one
      if (clen != 0 && $urandom_range(0, 1) == 0)
        k.chars ^= 64'h1 << (63 - $urandom_range(0, 8 * clen - 1));
      else
        k.len = (clen == MAX_KEY_CHARS) ? LEN_W'(clen - 1) : LEN_W'(clen + 1);
    end
    // fresh padding beyond the length must not matter
    k.chars = (k.chars & mask) | ({$urandom(), $urandom()} & ~mask);
    if (clen == MAX_KEY_CHARS && sel != 9) k.len = LEN_W'($urandom_range(8, 15));
    return k;
  endfunction

  // Offers one request and returns at the edge that takes it. Valid stays up
  // across back-to-back requests; it only drops when a gap is drawn.
  task automatic send_request(input logic [1:0] kind, input req_key_t k,
                              input logic [OFFSET_W-1:0] offset);
    int unsigned gap;
    // every third stretch of 40 requests goes without gaps
    gap = ((requests_sent / 40) % 3 == 2) ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.req_type      <= kind;
    req_ch.key_chars     <= k.chars;
    req_ch.key_length    <= k.len;
    req_ch.record_offset <= offset;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    requests_sent++;
    if (kind == REQ_ADD) begin
      if (key_pool.size() >= POOL_MAX) void'(key_pool.pop_front());
      key_pool = {key_pool, k};
    end else if (kind == REQ_CLEAR) begin
      key_pool.delete();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: draws a stall per response, with stall-free stretches and two
  // long hold-offs during which the sender keeps offering requests.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    responses_taken = 0;
    rsp_ch.ready    = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (responses_taken == 40 || responses_taken == 350)
        stall = HOLD_CYCLES;
      else if ((responses_taken / 50) % 4 == 3)
        stall = 0;
      else
        stall = $urandom_range(0, 10);
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      responses_taken++;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned adds;
    int unsigned roll;
    requests_sent        = 0;
    rst                  = 1'b1;
    req_ch.valid         = 1'b0;
    req_ch.req_type      = REQ_ADD;
    req_ch.key_chars     = '0;
    req_ch.key_length    = '0;
    req_ch.record_offset = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, unused code, empty key, one-char and full-width
    // keys, length saturation, padding past the length, duplicates (earliest
    // wins), equal chars with another length, then clear.
    send_request(REQ_LOOKUP, req_key_t'{64'h4142_4300_0000_0000, 4'd3}, 32'h0);
    send_request(REQ_CLEAR,  req_key_t'{64'h0, 4'd0}, 32'h0);
    send_request(REQ_UNUSED, req_key_t'{64'hFFFF_FFFF_FFFF_FFFF, 4'd15}, '1);
    send_request(REQ_ADD,    req_key_t'{64'hDEAD_BEEF_0123_4567, 4'd0}, 32'h0);
    send_request(REQ_ADD,    req_key_t'{64'hFF00_0000_0000_0000, 4'd1}, '1);
    send_request(REQ_ADD,    req_key_t'{64'hFFFF_FFFF_FFFF_FFFF, 4'd15}, 32'h1);
    send_request(REQ_ADD,    req_key_t'{64'h0, 4'd8}, 32'h2);
    send_request(REQ_ADD,    req_key_t'{64'h4142_0000_0000_0000, 4'd2}, 32'h100);
    send_request(REQ_ADD,    req_key_t'{64'h4142_0000_0000_0000, 4'd2}, 32'h200);
    send_request(REQ_ADD,    req_key_t'{64'h4142_5A5A_A5A5_1234, 4'd2}, 32'h300);
    send_request(REQ_ADD,    req_key_t'{64'h4100_0000_0000_0000, 4'd1}, 32'h10);
    send_request(REQ_ADD,    req_key_t'{64'h4142_4300_0000_0000, 4'd3}, 32'h20);
    send_request(REQ_LOOKUP, req_key_t'{64'h4142_FFFF_FFFF_FFFF, 4'd2}, '1);
    send_request(REQ_LOOKUP, req_key_t'{64'h1234_5678_9ABC_DEF0, 4'd0}, 32'h0);
    send_request(REQ_LOOKUP, req_key_t'{64'hFFFF_FFFF_FFFF_FFFF, 4'd9}, 32'h0);
    send_request(REQ_LOOKUP, req_key_t'{64'h0, 4'd8}, 32'h0);
    send_request(REQ_LOOKUP, req_key_t'{64'hFF12_3456_789A_BCDE, 4'd1}, 32'h0);
    send_request(REQ_LOOKUP, req_key_t'{64'h4143_0000_0000_0000, 4'd2}, 32'h0);
    send_request(REQ_LOOKUP, req_key_t'{64'h41FF_FFFF_FFFF_FFFF, 4'd1}, 32'h0);
    send_request(REQ_UNUSED, req_key_t'{64'h4142_0000_0000_0000, 4'd2}, 32'h55);
    send_request(REQ_LOOKUP, req_key_t'{64'h4142_0000_0000_0000, 4'd3}, 32'h0);
    send_request(REQ_CLEAR,  req_key_t'{64'hFFFF_FFFF_FFFF_FFFF, 4'd15}, '1);
    send_request(REQ_LOOKUP, req_key_t'{64'h4142_0000_0000_0000, 4'd2}, 32'h0);

    // Fill to capacity with lookups mixed in, then a few refused adds
    send_request(REQ_CLEAR, pick_key(), pick_offset());
    adds = 0;
    while (adds < INDEX_DEPTH + SPARE_ADDS) begin
      if ($urandom_range(0, 99) < 85) begin
        send_request(REQ_ADD, pick_key(), pick_offset());
        adds++;
      end else begin
        send_request(REQ_LOOKUP, pick_key(), pick_offset());
      end
    end

    // General mix; the occasional clear lets the table refill
    repeat (MIX_REQUESTS) begin
      roll = $urandom_range(0, 99);
      if (roll < 40)
        send_request(REQ_ADD, pick_key(), pick_offset());
      else if (roll < 85)
        send_request(REQ_LOOKUP, pick_key(), pick_offset());
      else if (roll < 92)
        send_request(REQ_CLEAR, pick_key(), pick_offset());
      else
        send_request(REQ_UNUSED, pick_key(), pick_offset());
    end

    @(negedge clk);
    req_ch.valid <= 1'b0;

    // drain; the watchdog covers a response that never comes
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.close_out();
    if (sb.mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

### sim.f
rtl/skis_pkg.sv
rtl/skis_if.sv
rtl/skis_cell.sv
rtl/skis_or_tree.sv
rtl/sorted_key_index_search.sv
sim/skis_index_scoreboard_pkg.sv
sim/tb_sorted_key_index_search.sv
